### src/scc_pkg.sv
// Shared types and constants for the second-chance cache set.
// Used by scc_cell and second_chance_cache_set; depends on nothing.
`default_nettype none

package scc_pkg;

  // Default sizes, handed to the top level as parameter defaults
  localparam int MAX_ENTRIES_DEF = 8;
  localparam int KEY_BITS_DEF    = 32;
  localparam int VALUE_BITS_DEF  = 32;

  // Request operation codes
  localparam logic [1:0] MODE_GET = 2'd0;
  localparam logic [1:0] MODE_PUT = 2'd1;
  localparam logic [1:0] MODE_DEL = 2'd2;

  // Result status codes
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_NO_KEY = 1'b1;

  // Capacity register: reset value and lowest effective value
  localparam logic [3:0] CAP_RESET = 4'd8;
  localparam logic [3:0] CAP_MIN   = 4'd2;

  // Command broadcast from the controller to every cell in the row
  typedef struct packed {
    logic touch;     // matching cell sets its reference bit
    logic write;     // matching cell also takes the request value
    logic remove;    // cells at and after the match shift toward the head
    logic append;    // first free cell takes the request key and value
    logic rotate;    // all valid cells shift toward the head, tail refills
    logic tail_new;  // on rotate, tail takes the request instead of the head
  } scc_cmd_t;

endpackage

`default_nettype wire

### src/scc_cell.sv
// One position of the ordered set: key, value, reference and valid bits.
// Depends on scc_pkg for the command struct; neighbors are wired by the top level.
`default_nettype none

module scc_cell #(
  parameter int KEY_BITS   = scc_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = scc_pkg::VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire scc_pkg::scc_cmd_t     cmd,
  input  wire logic [KEY_BITS-1:0]   req_key,
  input  wire logic [VALUE_BITS-1:0] req_value,
  input  wire logic [KEY_BITS-1:0]   head_key,
  input  wire logic [VALUE_BITS-1:0] head_value,
  input  wire logic [KEY_BITS-1:0]   nxt_key,
  input  wire logic [VALUE_BITS-1:0] nxt_value,
  input  wire logic                  nxt_ref,
  input  wire logic                  nxt_valid,
  input  wire logic                  prev_valid,
  input  wire logic                  seen_in,
  output logic [KEY_BITS-1:0]        key,
  output logic [VALUE_BITS-1:0]      value,
  output logic                       ref_bit,
  output logic                       valid,
  output logic                       hit,
  output logic                       seen_out
);

  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;
  logic                  ref_r, ref_nxt;
  logic                  valid_r, valid_nxt;

  // Match only on held entries; pass on whether a match lies at or before here
  assign hit      = valid_r && (key_r == req_key);
  assign seen_out = seen_in | hit;

  assign key     = key_r;
  assign value   = value_r;
  assign ref_bit = ref_r;
  assign valid   = valid_r;

  // Control bits: reference and valid
  always_comb begin
    ref_nxt   = ref_r;
    valid_nxt = valid_r;
    if (cmd.touch && hit) begin
      ref_nxt = 1'b1;
    end else if (cmd.remove && valid_r && seen_out) begin
      ref_nxt   = nxt_ref;
      valid_nxt = nxt_valid;
    end else if (cmd.append && !valid_r && prev_valid) begin
      ref_nxt   = 1'b0;
      valid_nxt = 1'b1;
    end else if (cmd.rotate && valid_r) begin
      ref_nxt = nxt_valid ? nxt_ref : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      ref_r   <= ref_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Payload: take the neighbor's entry, the head's, or the request
  always_ff @(posedge clk) begin
    if (cmd.touch && cmd.write && hit) begin
      value_r <= req_value;
    end else if (cmd.remove && valid_r && seen_out) begin
      key_r   <= nxt_key;
      value_r <= nxt_value;
    end else if (cmd.append && !valid_r && prev_valid) begin
      key_r   <= req_key;
      value_r <= req_value;
    end else if (cmd.rotate && valid_r) begin
      if (nxt_valid) begin
        key_r   <= nxt_key;
        value_r <= nxt_value;
      end else if (cmd.tail_new) begin
        key_r   <= req_key;
        value_r <= req_value;
      end else begin
        key_r   <= head_key;
        value_r <= head_value;
      end
    end
  end

endmodule

`default_nettype wire

### src/second_chance_cache_set.sv
// Top level of the second-chance cache set: request/result streams, controller
// and the row of scc_cell positions. Depends on scc_pkg and scc_cell.
//
// Usage:
//   Input stream in_*: in_tuser carries the operation (get, put, delete),
//   in_tdata the key (low bits) and the put value (high bits).
//   Result stream out_*: out_tuser carries the status (0 ok, 1 no key),
//   out_tdata the value read by a get that hit, else zero.
//   Config channel cfg_*: writes the 4-bit capacity; always ready. Write it
//   only while no request is in flight. Capacities below 2 act as 2, above
//   MAX_ENTRIES as MAX_ENTRIES.
// Timing:
//   A request is registered when taken and executed in ST_EXEC; its result
//   is registered and shows on out_tvalid when execution finishes. A put of
//   a new key into a full set first rotates one referenced head entry to the
//   tail per cycle, until the head entry is unreferenced, then evicts it.
//   The search compares all positions at once; the rotation moves the whole
//   row by one position per cycle.
// Reset: the set is empty and the capacity is 8.
// Stall: one finished result waits in the output register while the next
//   request is taken; the last execution step waits for that register.
`default_nettype none

module second_chance_cache_set #(
  parameter int MAX_ENTRIES = scc_pkg::MAX_ENTRIES_DEF,
  parameter int KEY_BITS    = scc_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS  = scc_pkg::VALUE_BITS_DEF,
  localparam int IN_W  = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((VALUE_BITS + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // request stream
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,   // key, write_value
  input  wire logic [1:0]       in_tuser,   // mode
  // result stream
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // read_value
  output logic [0:0]            out_tuser,  // status
  // capacity write
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [3:0]       cfg_data
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t                state_r, state_nxt;
  logic [1:0]            req_mode_r;
  logic [KEY_BITS-1:0]   req_key_r;
  logic [VALUE_BITS-1:0] req_value_r;
  logic [3:0]            cap_r;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  out_valid_r;
  logic                  out_status_r, out_status_nxt;
  logic [VALUE_BITS-1:0] out_value_r, out_value_nxt;

  scc_pkg::scc_cmd_t     cmd;
  logic                  load_out;

  // Row signals
  logic [KEY_BITS-1:0]   cell_key   [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] cell_value [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] cell_ref, cell_valid, cell_hit, cell_seen;
  logic [MAX_ENTRIES-1:0] nxt_ref_w, nxt_valid_w, prev_valid_w, seen_in_w;
  logic [KEY_BITS-1:0]   nxt_key_w  [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] nxt_value_w[MAX_ENTRIES];

  logic                  any_hit;
  logic [VALUE_BITS-1:0] hit_value;
  logic [3:0]            cap_eff;
  logic                  full;
  logic                  out_free;

  // Row of cells, each linked to its neighbors
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign nxt_key_w[i]   = '0;
      assign nxt_value_w[i] = '0;
      assign nxt_ref_w[i]   = 1'b0;
      assign nxt_valid_w[i] = 1'b0;
    end else begin : g_link
      assign nxt_key_w[i]   = cell_key[i+1];
      assign nxt_value_w[i] = cell_value[i+1];
      assign nxt_ref_w[i]   = cell_ref[i+1];
      assign nxt_valid_w[i] = cell_valid[i+1];
    end
    if (i == 0) begin : g_head
      assign prev_valid_w[i] = 1'b1;
      assign seen_in_w[i]    = 1'b0;
    end else begin : g_body
      assign prev_valid_w[i] = cell_valid[i-1];
      assign seen_in_w[i]    = cell_seen[i-1];
    end

    scc_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .req_key    (req_key_r),
      .req_value  (req_value_r),
      .head_key   (cell_key[0]),
      .head_value (cell_value[0]),
      .nxt_key    (nxt_key_w[i]),
      .nxt_value  (nxt_value_w[i]),
      .nxt_ref    (nxt_ref_w[i]),
      .nxt_valid  (nxt_valid_w[i]),
      .prev_valid (prev_valid_w[i]),
      .seen_in    (seen_in_w[i]),
      .key        (cell_key[i]),
      .value      (cell_value[i]),
      .ref_bit    (cell_ref[i]),
      .valid      (cell_valid[i]),
      .hit        (cell_hit[i]),
      .seen_out   (cell_seen[i])
    );
  end

  // Collect the matching value (keys are unique among held entries)
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (cell_hit[i]) begin
        hit_value = hit_value | cell_value[i];
      end
    end
  end

  assign any_hit = |cell_hit;

  // Clamp capacity and decide whether a new key must evict
  assign cap_eff = (cap_r < scc_pkg::CAP_MIN) ? scc_pkg::CAP_MIN : cap_r;
  assign full    = (CMP_W'(count_r) >= CMP_W'(cap_eff)) ||
                   (count_r == CNT_W'(MAX_ENTRIES));

  assign out_free = !out_valid_r || out_tready;

  // Controller: decode the held request into one row command per cycle
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    load_out       = 1'b0;
    count_nxt      = count_r;
    out_status_nxt = scc_pkg::STATUS_OK;
    out_value_nxt  = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (req_mode_r == scc_pkg::MODE_PUT && !any_hit && full && cell_ref[0]) begin
          // give the head a second chance: clear its bit, move it to the tail
          cmd.rotate = 1'b1;
        end else if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
          case (req_mode_r)
            scc_pkg::MODE_GET: begin
              if (any_hit) begin
                cmd.touch     = 1'b1;
                out_value_nxt = hit_value;
              end else begin
                out_status_nxt = scc_pkg::STATUS_NO_KEY;
              end
            end
            scc_pkg::MODE_PUT: begin
              if (any_hit) begin
                cmd.touch = 1'b1;
                cmd.write = 1'b1;
              end else if (full) begin
                // evict the head and append the new entry in one shift
                cmd.rotate   = 1'b1;
                cmd.tail_new = 1'b1;
              end else begin
                cmd.append = 1'b1;
                count_nxt  = count_r + CNT_W'(1);
              end
            end
            scc_pkg::MODE_DEL: begin
              if (any_hit) begin
                cmd.remove = 1'b1;
                count_nxt  = count_r - CNT_W'(1);
              end else begin
                out_status_nxt = scc_pkg::STATUS_NO_KEY;
              end
            end
            default: begin
              out_status_nxt = scc_pkg::STATUS_NO_KEY;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cap_r       <= scc_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the accepted request and the finished result
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_mode_r  <= in_tuser;
      req_key_r   <= in_tdata[KEY_BITS-1:0];
      req_value_r <= in_tdata[KEY_BITS +: VALUE_BITS];
    end
    if (load_out) begin
      out_status_r <= out_status_nxt;
      out_value_r  <= out_value_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_W'(out_value_r);

`ifndef ASSERT_OFF
  // The number of held entries matches the entry count
  a_valid_run: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(count_r))
    else $error("valid bits disagree with entry count");

  // Keys stay unique, so at most one position matches
  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cell_hit))
    else $error("key held at more than one position");

  // Rotation happens only on a miss into a full set
  a_rotate_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rotate |-> (full && !any_hit && req_mode_r == scc_pkg::MODE_PUT))
    else $error("rotation outside a put miss into a full set");

  // An append grows the set by exactly one entry
  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("append did not grow the entry count");

  // A result is produced only when the output register can take it
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_tready))
    else $error("result overwrote a pending result");
`endif

endmodule

`default_nettype wire
